FILE: rtl/usf_pkg.sv
// ============================================================================
// usf_pkg: shared types and helpers for the UTF-16 surrogate fixer
// Surrogate tags, replacement words and the request passed from front to back.
// ============================================================================
`default_nettype none

package usf_pkg;

    localparam logic [15:0] SURR_MASK = 16'hfc00;
    localparam logic [15:0] HIGH_TAG  = 16'hd800;
    localparam logic [15:0] LOW_TAG   = 16'hdc00;
    localparam logic [15:0] REPL_LE   = 16'hfffd;
    localparam logic [15:0] REPL_BE   = 16'hfdff;

    // Three entries absorb the extra word of an end-of-string request at full rate.
    localparam int QUEUE_DEPTH = 3;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One request per accepted unit that ends the string or finds a unit held:
    // the held unit to release and/or the final unit, both already resolved.
    typedef struct packed {
        logic        held_emit;
        logic [15:0] held_unit;
        logic        cur_emit;
        logic [15:0] cur_unit;
    } usf_req_t;

    function automatic logic [15:0] to_value(input logic [15:0] raw, input logic bo);
        return bo ? {raw[7:0], raw[15:8]} : raw;
    endfunction

    function automatic logic is_high(input logic [15:0] raw, input logic bo);
        return (to_value(raw, bo) & SURR_MASK) == HIGH_TAG;
    endfunction

    function automatic logic is_low(input logic [15:0] raw, input logic bo);
        return (to_value(raw, bo) & SURR_MASK) == LOW_TAG;
    endfunction

    function automatic logic [15:0] replacement(input logic bo);
        return bo ? REPL_BE : REPL_LE;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/usf_front.sv
// ============================================================================
// usf_front: accept and classify code units
// Holds one unit back, resolves pairing and pushes a request per later or last unit.
// ============================================================================
`default_nettype none

module usf_front
    import usf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        byte_order,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] code_unit
    input  wire logic        s_tlast,    // end_of_string
    input  wire logic        q_full,
    output logic             q_push,
    output usf_req_t         q_req
);

    logic [15:0] held_unit_reg, held_unit_next;
    logic        held_valid_reg, held_valid_next;
    logic        accept;
    logic        prev_high;
    logic [15:0] cur_fixed;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        prev_high = held_valid_reg && is_high(held_unit_reg, byte_order);

        q_req.held_emit = held_valid_reg;
        q_req.held_unit = (prev_high && !is_low(s_tdata, byte_order))
                        ? replacement(byte_order) : held_unit_reg;

        // A low surrogate without a high one just before it is unpaired.
        cur_fixed = (is_low(s_tdata, byte_order) && !prev_high)
                  ? replacement(byte_order) : s_tdata;
        q_req.cur_emit = s_tlast;
        q_req.cur_unit = (s_tlast && is_high(cur_fixed, byte_order))
                       ? replacement(byte_order) : cur_fixed;

        // Nothing to send for a first unit that is not also the last.
        q_push = accept && (held_valid_reg || s_tlast);

        held_unit_next  = held_unit_reg;
        held_valid_next = held_valid_reg;
        if (accept) begin
            held_unit_next  = s_tlast ? 16'h0000 : cur_fixed;
            held_valid_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_unit_reg  <= 16'h0000;
            held_valid_reg <= 1'b0;
        end else begin
            held_unit_reg  <= held_unit_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/usf_queue.sv
// ============================================================================
// usf_queue: short request queue between front and back
// Three-entry FIFO; push and pop may happen in the same cycle.
// ============================================================================
`default_nettype none

module usf_queue
    import usf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  usf_req_t  push_req,
    input  wire logic pop,
    output usf_req_t  head_req,
    output logic      empty,
    output logic      full
);

    usf_req_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_req = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/usf_back.sv
// ============================================================================
// usf_back: emit resolved code units
// Pops requests and drives the output register, one or two words each.
// ============================================================================
`default_nettype none

module usf_back
    import usf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  usf_req_t         head_req,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [15:0] fixed_unit
    output logic             m_tlast     // last_out
);

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_unit_reg, out_unit_next;
    logic        out_last_reg, out_last_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [15:0] pend_unit_reg, pend_unit_next;
    logic        advance;

    assign advance  = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_unit_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_unit_next   = out_unit_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        q_pop           = 1'b0;
        if (advance) begin
            priority if (pend_valid_reg) begin
                // second word of an end-of-string request
                out_valid_next  = 1'b1;
                out_unit_next   = pend_unit_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end else if (!q_empty) begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                if (head_req.held_emit) begin
                    out_unit_next   = head_req.held_unit;
                    out_last_next   = 1'b0;
                    pend_valid_next = head_req.cur_emit;
                    pend_unit_next  = head_req.cur_unit;
                end else begin
                    out_unit_next = head_req.cur_unit;
                    out_last_next = 1'b1;
                end
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_unit_reg  <= out_unit_next;
        out_last_reg  <= out_last_next;
        pend_unit_reg <= pend_unit_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/utf16_surrogate_fixer_core.sv
// ============================================================================
// utf16_surrogate_fixer_core: replace unpaired UTF-16 surrogates with U+FFFD
// Front classifies units, a three-entry queue decouples it from the back end.
// ============================================================================
//
//  channel  | direction | tdata            | tlast
//  ---------+-----------+------------------+---------------
//  s_       | in        | [15:0] code_unit | end_of_string
//  m_       | out       | [15:0] fixed_unit| last_out
//  cfg_     | in        | [0] byte_order   | -
//
//  One unit accepted per cycle while the request queue is not full; output
//  lags input by one unit, and the last unit of a string yields two output
//  words when a unit is held. A released word passes through the request
//  queue and the output register before it is valid on m_.
//  Reset (aresetn low, synchronous) drops the held unit and empties the queue.
//  s_tready falls only when the request queue is full behind a stalled m_.
//
`default_nettype none

module utf16_surrogate_fixer_core
    import usf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,  // [0] byte_order
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] code_unit
    input  wire logic        s_tlast,    // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [15:0] fixed_unit
    output logic             m_tlast     // last_out
);

    logic     byte_order_reg;
    logic     q_push, q_pop, q_empty, q_full;
    usf_req_t push_req, head_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_order_reg <= 1'b0;
        end else if (cfg_we) begin
            byte_order_reg <= cfg_wdata;
        end
    end

    usf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_order (byte_order_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_req      (push_req)
    );

    usf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (push_req),
        .pop      (q_pop),
        .head_req (head_req),
        .empty    (q_empty),
        .full     (q_full)
    );

    usf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_req (head_req),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/usf_checker.sv
// ============================================================================
// usf_checker: port-level checks for the surrogate fixer
// Watches the ports over time and flags outputs that break the contract.
// ============================================================================
`default_nettype none

module usf_checker
    import usf_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic        cfg_wdata,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    logic bo_reg;

    // track the byte order the block is using
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bo_reg <= 1'b0;
        end else if (cfg_we) begin
            bo_reg <= cfg_wdata;
        end
    end

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // nothing leaves in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the final word of a string is never a high surrogate
    a_last_not_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !is_high(m_tdata, bo_reg))
        else $error("string ends on a high surrogate");

    // the input is open in the cycle after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind utf16_surrogate_fixer_core usf_checker u_usf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

`default_nettype wire
